// ----- hdl/lgps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgps_pkg
// Shared widths, register indexes and reset values of the gait phase scheduler.
// ----------------------------------------------------------------------------
package lgps_pkg;

  localparam int TICK_W     = 32;
  localparam int SEGCNT_W   = 5;
  localparam int TPS_W      = 8;
  localparam int OFFS_W     = 16;
  localparam int DURS_W     = 20;
  localparam int OFF_W      = 4;
  localparam int DUR_W      = 5;
  localparam int DT_W       = DUR_W + TPS_W;
  localparam int NUM_LEGS   = 4;
  localparam int PROG_W     = 16;
  localparam int ROW_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int TPS_MAX = (1 << TPS_W) - 1;

  localparam int MAX_SEGMENTS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // phase above 19/20 of the period flags the cycle end
  localparam int NEAR_NUM = 19;
  localparam int NEAR_DEN = 20;

  localparam logic [SEGCNT_W-1:0] SEGCNT_RST = 5'd10;
  localparam logic [TPS_W-1:0]    TPS_RST    = 8'd1;
  localparam logic [OFFS_W-1:0]   OFFS_RST   = 16'd0;
  localparam logic [DURS_W-1:0]   DURS_RST   = 20'd169125;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEGMENT_COUNT     = 3'd0,
    CFG_TICKS_PER_SEGMENT = 3'd1,
    CFG_LEG_OFFSETS       = 3'd2,
    CFG_LEG_DURATIONS     = 3'd3
  } cfg_idx_t;

endpackage

// ----- hdl/lgps_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgps_in_if
// Input item channel: one control-tick count per item.
// ----------------------------------------------------------------------------
interface lgps_in_if;
  logic                       valid;
  logic                       ready;
  logic [lgps_pkg::TICK_W-1:0] tick_count;

  modport source (output valid, output tick_count, input ready);
  modport sink   (input valid, input tick_count, output ready);
endinterface

// ----- hdl/lgps_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgps_out_if
// Result item channel: leg progress, cycle end flag and one horizon row.
// ----------------------------------------------------------------------------
interface lgps_out_if;
  logic                        valid;
  logic                        ready;
  logic [lgps_pkg::PROG_W-1:0] contact_progress_0;
  logic [lgps_pkg::PROG_W-1:0] contact_progress_1;
  logic [lgps_pkg::PROG_W-1:0] contact_progress_2;
  logic [lgps_pkg::PROG_W-1:0] contact_progress_3;
  logic [lgps_pkg::PROG_W-1:0] swing_progress_0;
  logic [lgps_pkg::PROG_W-1:0] swing_progress_1;
  logic [lgps_pkg::PROG_W-1:0] swing_progress_2;
  logic [lgps_pkg::PROG_W-1:0] swing_progress_3;
  logic                        near_cycle_end;
  logic [lgps_pkg::ROW_W-1:0]  horizon_stance_row;
  logic                        last_row;

  modport source (
    output valid, input ready,
    output contact_progress_0, output contact_progress_1,
    output contact_progress_2, output contact_progress_3,
    output swing_progress_0, output swing_progress_1,
    output swing_progress_2, output swing_progress_3,
    output near_cycle_end, output horizon_stance_row, output last_row
  );
  modport sink (
    input valid, output ready,
    input contact_progress_0, input contact_progress_1,
    input contact_progress_2, input contact_progress_3,
    input swing_progress_0, input swing_progress_1,
    input swing_progress_2, input swing_progress_3,
    input near_cycle_end, input horizon_stance_row, input last_row
  );
endinterface

// ----- hdl/lgps_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lgps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lgps_pkg::CFG_IDX_W-1:0]  index;
  logic [lgps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/legged_gait_phase_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legged_gait_phase_scheduler
// Offset/duration gait scheduler: leg progress fractions and horizon rows.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one control-tick count per item. cfg_bus, always ready,
//   writes segment count, ticks per segment, leg offsets and leg durations by
//   index; the user must write it only while idle, which is not enforced.
//   For every item the block emits one result item per gait segment on
//   out_bus; all rows of an item repeat the leg progress fields and the cycle
//   end flag, and the final row carries last_row.
//   All divisions run through one shared bit-serial divider: 32 steps for
//   the phase, one step per phase bit for the segment, 4 steps per leg offset
//   and FRACTION_BITS steps per progress fraction, all before the first row.
//   Rows then leave one per cycle while out_bus is ready.
//   in_bus is ready only between items; a result waiting in the output
//   register does not block the next item from being taken.
//   A stalled receiver holds the current row and pauses the row sequencer.
//   Synchronous reset restores the register defaults and empties the block.
// ----------------------------------------------------------------------------
module legged_gait_phase_scheduler #(
  parameter int MAX_SEGMENTS  = lgps_pkg::MAX_SEGMENTS_DEF,
  parameter int FRACTION_BITS = lgps_pkg::FRACTION_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lgps_in_if.sink    in_bus,
  lgps_out_if.source out_bus,
  lgps_cfg_if.sink   cfg_bus
);

  localparam int NL  = lgps_pkg::NUM_LEGS;
  localparam int SW  = $clog2(MAX_SEGMENTS + 1);
  localparam int PW  = $clog2(MAX_SEGMENTS * lgps_pkg::TPS_MAX + 1);
  localparam int DW  = (PW > lgps_pkg::DT_W) ? PW : lgps_pkg::DT_W;
  localparam int WW  = DW + 2;
  localparam int QW  = (FRACTION_BITS > PW) ? FRACTION_BITS : PW;
  localparam int NW  = lgps_pkg::TICK_W;
  localparam int STW = $clog2(NW + 1);
  localparam int XW  = (SW > lgps_pkg::SEGCNT_W) ? SW : lgps_pkg::SEGCNT_W;
  localparam int RW  = ((SW > lgps_pkg::DUR_W) ? SW : lgps_pkg::DUR_W) + 1;
  localparam int EW  = PW + 5;
  localparam int FW  = FRACTION_BITS + lgps_pkg::PROG_W;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_PER    = 11'b00000000010,
    ST_DIVP   = 11'b00000000100,
    ST_DIVSEG = 11'b00000001000,
    ST_DIVOFF = 11'b00000010000,
    ST_MULO   = 11'b00000100000,
    ST_MULD   = 11'b00001000000,
    ST_CALC   = 11'b00010000000,
    ST_DIVC   = 11'b00100000000,
    ST_DIVS   = 11'b01000000000,
    ST_ROWS   = 11'b10000000000
  } state_t;

  // configuration registers
  logic [lgps_pkg::SEGCNT_W-1:0] seg_cnt_r;
  logic [lgps_pkg::TPS_W-1:0]    tps_r;
  logic [lgps_pkg::OFFS_W-1:0]   offs_r;
  logic [lgps_pkg::DURS_W-1:0]   durs_r;

  state_t                     state_r;
  logic                       wait_r;
  logic [NW-1:0]              tick_r;
  logic [SW-1:0]              s_r;
  logic [lgps_pkg::TPS_W-1:0] t_r;
  logic [PW-1:0]              per_r;
  logic [PW-1:0]              p_r;
  logic [SW-1:0]              seg_r;
  logic                       end_r;
  logic [SW-1:0]              off_r [NL];
  logic [1:0]                 leg_r;
  logic [PW-1:0]              ot_r;
  logic [lgps_pkg::DT_W-1:0]  dt_r;
  logic signed [WW-1:0]       ec_r;
  logic signed [WW-1:0]       so_r;
  logic signed [WW-1:0]       sd_r;
  logic signed [WW-1:0]       es_r;
  logic [lgps_pkg::PROG_W-1:0] cp_r [NL];
  logic [lgps_pkg::PROG_W-1:0] sp_r [NL];
  logic [SW-1:0]              it_r;
  logic [SW-1:0]              k_r;

  logic                        out_valid_r;
  logic [lgps_pkg::PROG_W-1:0] out_cp_r [NL];
  logic [lgps_pkg::PROG_W-1:0] out_sp_r [NL];
  logic                        out_end_r;
  logic [lgps_pkg::ROW_W-1:0]  out_row_r;
  logic                        out_last_r;

  // divider hookup
  logic           div_start;
  logic [DW-1:0]  div_rem_in;
  logic [NW-1:0]  div_num;
  logic [DW-1:0]  div_den;
  logic [STW-1:0] div_steps;
  logic           div_done;
  logic [QW-1:0]  div_q;
  logic [DW-1:0]  div_rem;

  lgps_div #(
    .NW  (NW),
    .DW  (DW),
    .QW  (QW),
    .STW (STW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_in),
    .num      (div_num),
    .den      (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // input acceptance
  logic                       in_take;
  logic [SW-1:0]              s_nxt;
  logic [lgps_pkg::TPS_W-1:0] t_nxt;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign in_take       = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  always_comb begin
    if (seg_cnt_r == '0) begin
      s_nxt = SW'(1);
    end else if (XW'(seg_cnt_r) > XW'(MAX_SEGMENTS)) begin
      s_nxt = SW'(MAX_SEGMENTS);
    end else begin
      s_nxt = SW'(seg_cnt_r);
    end
    t_nxt = (tps_r == '0) ? lgps_pkg::TPS_W'(1) : tps_r;
  end

  // per-leg fields
  logic [lgps_pkg::OFF_W-1:0] raw_off;
  logic [lgps_pkg::DUR_W-1:0] dur_cur;

  assign raw_off = offs_r[leg_r * lgps_pkg::OFF_W +: lgps_pkg::OFF_W];
  assign dur_cur = durs_r[leg_r * lgps_pkg::DUR_W +: lgps_pkg::DUR_W];

  // window arithmetic
  logic signed [WW-1:0] p_s, per_s, ot_s, dt_s;
  logic signed [WW-1:0] ec_d, ec_nxt, so_sum, so_nxt, sd_nxt, es_d, es_nxt;
  logic                 c_ok, c_full, s_ok, s_full;
  logic [EW-1:0]        near_lhs, near_rhs;

  always_comb begin
    p_s    = $signed(WW'(p_r));
    per_s  = $signed(WW'(per_r));
    ot_s   = $signed(WW'(ot_r));
    dt_s   = $signed(WW'(dt_r));
    ec_d   = p_s - ot_s;
    ec_nxt = (ec_d < 0) ? ec_d + per_s : ec_d;
    so_sum = ot_s + dt_s;
    so_nxt = (so_sum > per_s) ? so_sum - per_s : so_sum;
    sd_nxt = per_s - dt_s;
    es_d   = p_s - so_r;
    es_nxt = (es_d < 0) ? es_d + per_s : es_d;
    c_ok   = (dt_r != '0) && (ec_r <= dt_s);
    c_full = (ec_r == dt_s);
    s_ok   = (sd_r > 0) && (es_r >= 0) && (es_r <= sd_r);
    s_full = (es_r == sd_r);
    near_lhs = EW'(p_r) * EW'(lgps_pkg::NEAR_DEN);
    near_rhs = EW'(per_r) * EW'(lgps_pkg::NEAR_NUM);
  end

  // fraction formatting
  logic [FW-1:0]               q_ext, top_ext;
  logic [lgps_pkg::PROG_W-1:0] frac_val, frac_top;

  always_comb begin
    q_ext    = {{lgps_pkg::PROG_W{1'b0}}, div_q[FRACTION_BITS-1:0]};
    top_ext  = {{lgps_pkg::PROG_W{1'b0}}, {FRACTION_BITS{1'b1}}};
    frac_val = q_ext[lgps_pkg::PROG_W-1:0];
    frac_top = top_ext[lgps_pkg::PROG_W-1:0];
  end

  // divider operand select
  always_comb begin
    div_start  = 1'b0;
    div_rem_in = '0;
    div_num    = '0;
    div_den    = DW'(1);
    div_steps  = STW'(1);
    unique case (state_r)
      ST_DIVP: begin
        div_start = !wait_r;
        div_num   = tick_r;
        div_den   = DW'(per_r);
        div_steps = STW'(NW);
      end
      ST_DIVSEG: begin
        div_start = !wait_r;
        div_num   = {p_r, {(NW - PW){1'b0}}};
        div_den   = DW'(t_r);
        div_steps = STW'(PW);
      end
      ST_DIVOFF: begin
        div_start = !wait_r;
        div_num   = {raw_off, {(NW - lgps_pkg::OFF_W){1'b0}}};
        div_den   = DW'(s_r);
        div_steps = STW'(lgps_pkg::OFF_W);
      end
      ST_DIVC: begin
        div_start  = !wait_r && c_ok && !c_full;
        div_rem_in = ec_r[DW-1:0];
        div_den    = dt_s[DW-1:0];
        div_steps  = STW'(FRACTION_BITS);
      end
      ST_DIVS: begin
        div_start  = !wait_r && s_ok && !s_full;
        div_rem_in = es_r[DW-1:0];
        div_den    = sd_r[DW-1:0];
        div_steps  = STW'(FRACTION_BITS);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // horizon row
  logic [lgps_pkg::ROW_W-1:0] row_bits;
  logic signed [RW-1:0]       row_d [NL];
  logic                       row_load;
  logic                       row_last;
  logic [SW-1:0]              it_inc;
  logic [SW-1:0]              seg_inc;

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      row_d[j] = $signed(RW'(it_r)) - $signed(RW'(off_r[j]));
      if (row_d[j] < 0) begin
        row_d[j] = row_d[j] + $signed(RW'(s_r));
      end
      row_bits[j] = row_d[j] <
                    $signed(RW'(durs_r[j * lgps_pkg::DUR_W +: lgps_pkg::DUR_W]));
    end
    row_load = (state_r == ST_ROWS) && (!out_valid_r || out_bus.ready);
    row_last = (k_r == s_r - SW'(1));
    it_inc   = (it_r + SW'(1) == s_r) ? '0 : it_r + SW'(1);
    seg_inc  = (seg_r + SW'(1) == s_r) ? '0 : seg_r + SW'(1);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= lgps_pkg::SEGCNT_RST;
      tps_r     <= lgps_pkg::TPS_RST;
      offs_r    <= lgps_pkg::OFFS_RST;
      durs_r    <= lgps_pkg::DURS_RST;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      unique case (cfg_bus.index)
        lgps_pkg::CFG_SEGMENT_COUNT: begin
          seg_cnt_r <= cfg_bus.data[lgps_pkg::SEGCNT_W-1:0];
        end
        lgps_pkg::CFG_TICKS_PER_SEGMENT: begin
          tps_r <= cfg_bus.data[lgps_pkg::TPS_W-1:0];
        end
        lgps_pkg::CFG_LEG_OFFSETS: begin
          offs_r <= cfg_bus.data[lgps_pkg::OFFS_W-1:0];
        end
        lgps_pkg::CFG_LEG_DURATIONS: begin
          durs_r <= cfg_bus.data[lgps_pkg::DURS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= 1'b0;
      leg_r   <= '0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            state_r <= ST_PER;
          end
        end
        ST_PER: begin
          state_r <= ST_DIVP;
        end
        ST_DIVP: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_done) begin
            wait_r  <= 1'b0;
            state_r <= ST_DIVSEG;
          end
        end
        ST_DIVSEG: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_done) begin
            wait_r  <= 1'b0;
            leg_r   <= '0;
            state_r <= ST_DIVOFF;
          end
        end
        ST_DIVOFF: begin
          if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_done) begin
            wait_r <= 1'b0;
            leg_r  <= leg_r + 2'd1;
            if (leg_r == 2'(NL - 1)) begin
              state_r <= ST_MULO;
            end
          end
        end
        ST_MULO: begin
          state_r <= ST_MULD;
        end
        ST_MULD: begin
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          state_r <= ST_DIVC;
        end
        ST_DIVC: begin
          if (!wait_r) begin
            if (c_ok && !c_full) begin
              wait_r <= 1'b1;
            end else begin
              state_r <= ST_DIVS;
            end
          end else if (div_done) begin
            wait_r  <= 1'b0;
            state_r <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          if (!wait_r && !(s_ok && !s_full)) begin
            leg_r   <= leg_r + 2'd1;
            state_r <= (leg_r == 2'(NL - 1)) ? ST_ROWS : ST_MULO;
            k_r     <= '0;
          end else if (!wait_r) begin
            wait_r <= 1'b1;
          end else if (div_done) begin
            wait_r  <= 1'b0;
            leg_r   <= leg_r + 2'd1;
            state_r <= (leg_r == 2'(NL - 1)) ? ST_ROWS : ST_MULO;
            k_r     <= '0;
          end
        end
        ST_ROWS: begin
          if (row_load) begin
            k_r <= k_r + SW'(1);
            if (row_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r <= in_bus.tick_count;
      s_r    <= s_nxt;
      t_r    <= t_nxt;
    end
    if (state_r == ST_PER) begin
      per_r <= PW'(s_r * t_r);
    end
    if (state_r == ST_DIVP && wait_r && div_done) begin
      p_r <= div_rem[PW-1:0];
    end
    if (state_r == ST_DIVSEG) begin
      end_r <= near_lhs > near_rhs;
      if (wait_r && div_done) begin
        seg_r <= div_q[SW-1:0];
      end
    end
    if (state_r == ST_DIVOFF && wait_r && div_done) begin
      off_r[leg_r] <= div_rem[SW-1:0];
    end
    if (state_r == ST_MULO) begin
      ot_r <= PW'(off_r[leg_r] * t_r);
    end
    if (state_r == ST_MULD) begin
      dt_r <= lgps_pkg::DT_W'(dur_cur * t_r);
    end
    if (state_r == ST_CALC) begin
      ec_r <= ec_nxt;
      so_r <= so_nxt;
      sd_r <= sd_nxt;
    end
    if (state_r == ST_DIVC) begin
      es_r <= es_nxt;
      if (!wait_r && !c_ok) begin
        cp_r[leg_r] <= '0;
      end else if (!wait_r && c_full) begin
        cp_r[leg_r] <= frac_top;
      end else if (wait_r && div_done) begin
        cp_r[leg_r] <= frac_val;
      end
    end
    if (state_r == ST_DIVS) begin
      if (!wait_r && !s_ok) begin
        sp_r[leg_r] <= '0;
      end else if (!wait_r && s_full) begin
        sp_r[leg_r] <= frac_top;
      end else if (wait_r && div_done) begin
        sp_r[leg_r] <= frac_val;
      end
      it_r <= seg_inc;
    end
    if (row_load) begin
      it_r <= it_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_load) begin
      out_cp_r   <= cp_r;
      out_sp_r   <= sp_r;
      out_end_r  <= end_r;
      out_row_r  <= row_bits;
      out_last_r <= row_last;
    end
  end

  assign out_bus.valid              = out_valid_r;
  assign out_bus.contact_progress_0 = out_cp_r[0];
  assign out_bus.contact_progress_1 = out_cp_r[1];
  assign out_bus.contact_progress_2 = out_cp_r[2];
  assign out_bus.contact_progress_3 = out_cp_r[3];
  assign out_bus.swing_progress_0   = out_sp_r[0];
  assign out_bus.swing_progress_1   = out_sp_r[1];
  assign out_bus.swing_progress_2   = out_sp_r[2];
  assign out_bus.swing_progress_3   = out_sp_r[3];
  assign out_bus.near_cycle_end     = out_end_r;
  assign out_bus.horizon_stance_row = out_row_r;
  assign out_bus.last_row           = out_last_r;

endmodule

// ----- hdl/lgps_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgps_div
// Shared restoring divider, one quotient bit per cycle, preset remainder and
// variable step count.
// ----------------------------------------------------------------------------
module lgps_div #(
  parameter int NW  = 32,
  parameter int DW  = 14,
  parameter int QW  = 16,
  parameter int STW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [STW-1:0] steps,
  output logic          done,
  output logic [QW-1:0] quot,
  output logic [DW-1:0] rem
);

  logic           busy_r;
  logic           done_r;
  logic [STW-1:0] cnt_r;
  logic [DW-1:0]  r_r;
  logic [NW-1:0]  n_r;
  logic [QW-1:0]  q_r;

  logic [DW:0] r2;
  logic [DW:0] diff;
  logic        ge;

  always_comb begin
    r2   = {r_r, n_r[NW-1]};
    ge   = r2 >= {1'b0, den};
    diff = r2 - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - STW'(1);
      if (cnt_r == STW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r <= rem_init;
      n_r <= num;
      q_r <= '0;
    end else if (busy_r) begin
      r_r <= ge ? diff[DW-1:0] : r2[DW-1:0];
      n_r <= {n_r[NW-2:0], 1'b0};
      q_r <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule
